[sv/slcd_pkg.sv]
// shared types and constants of the sync/length/checksum deframer
package slcd_pkg;

    // frame layout constants
    localparam logic [7:0] SYNC_BYTE0 = 8'h55;
    localparam logic [7:0] SYNC_BYTE1 = 8'hAA;
    localparam logic [7:0] SYNC_BYTE2 = 8'h02;

    // payload size limit of the receive buffer
    localparam int MAX_PAYLOAD_BYTES = 128;
    localparam int LEN_W             = 16;
    localparam logic [LEN_W:0] LEN_LIMIT = (LEN_W + 1)'(MAX_PAYLOAD_BYTES);

    // configuration register reset values
    localparam logic [7:0] MAX_COMMAND_RESET = 8'h24;
    localparam logic [6:0] MAX_PAYLOAD_RESET = 7'd127;

    // configuration port geometry
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_COMMAND = 1'b0,
        REG_MAX_PAYLOAD = 1'b1
    } cfg_reg_t;

    // parser phases
    typedef enum logic [3:0] {
        PH_SYNC0 = 4'd0,
        PH_SYNC1 = 4'd1,
        PH_SYNC2 = 4'd2,
        PH_HDR0  = 4'd3,
        PH_HDR1  = 4'd4,
        PH_CMD   = 4'd5,
        PH_LENH  = 4'd6,
        PH_LENL  = 4'd7,
        PH_DATA  = 4'd8
    } phase_t;

    // one result item
    typedef struct packed {
        logic       end_of_frame;
        logic [7:0] payload_byte;
        logic [6:0] byte_index;
        logic [7:0] command;
        logic [6:0] frame_length;
        logic       checksum_ok;
    } result_t;

endpackage

[sv/slcd_byte_if.sv]
// received byte channel and result channel interfaces
interface slcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_burst;

    modport source (output valid, rx_byte, end_of_burst, input ready);
    modport sink   (input valid, rx_byte, end_of_burst, output ready);
endinterface

interface slcd_result_if;
    logic       valid;
    logic       ready;
    logic       end_of_frame;
    logic [7:0] payload_byte;
    logic [6:0] byte_index;
    logic [7:0] command;
    logic [6:0] frame_length;
    logic       checksum_ok;

    modport source (output valid, end_of_frame, payload_byte, byte_index, command,
                    frame_length, checksum_ok, input ready);
    modport sink   (input valid, end_of_frame, payload_byte, byte_index, command,
                    frame_length, checksum_ok, output ready);
endinterface

[sv/slcd_parser.sv]
// frame parser: phase state machine, running checksum and result formation
module slcd_parser
    import slcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic       end_of_burst,
    input  logic [7:0] max_command,
    input  logic [6:0] max_payload,
    output logic       res_valid,
    output result_t    res
);

    phase_t     phase_reg, phase_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] len_high_reg, len_high_next;
    logic [6:0] length_reg, length_next;
    logic [6:0] count_reg, count_next;

    logic [LEN_W-1:0] len;
    logic             len_ok;

    // full header length and its range check
    assign len    = {len_high_reg, rx_byte};
    assign len_ok = (len <= LEN_W'(max_payload)) && ({1'b0, len} < LEN_LIMIT);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SYNC0;
            sum_reg      <= '0;
            command_reg  <= '0;
            len_high_reg <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            sum_reg      <= sum_next;
            command_reg  <= command_next;
            len_high_reg <= len_high_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
        end
    end

    // next state and result of the byte at hand
    always_comb
    begin
        phase_next    = PH_SYNC0;
        sum_next      = sum_reg;
        command_next  = command_reg;
        len_high_next = len_high_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        res_valid     = 1'b0;
        res           = '{end_of_frame: 1'b0, payload_byte: 8'd0, byte_index: 7'd0,
                          command: command_reg, frame_length: length_reg,
                          checksum_ok: 1'b0};

        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (rx_byte == SYNC_BYTE1)
                begin
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (rx_byte == SYNC_BYTE2)
                begin
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_HDR0;
                end
            end
            PH_HDR0:
            begin
                sum_next   = sum_reg + rx_byte;
                phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                sum_next   = sum_reg + rx_byte;
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                if (rx_byte <= max_command)
                begin
                    command_next = rx_byte;
                    sum_next     = sum_reg + rx_byte;
                    phase_next   = PH_LENH;
                end
            end
            PH_LENH:
            begin
                len_high_next = rx_byte;
                phase_next    = PH_LENL;
            end
            PH_LENL:
            begin
                if (len_ok)
                begin
                    length_next = rx_byte[6:0];
                    count_next  = '0;
                    sum_next    = sum_reg + len_high_reg + rx_byte;
                    phase_next  = PH_DATA;
                end
            end
            PH_DATA:
            begin
                res_valid = 1'b1;
                if (count_reg < length_reg)
                begin
                    res.payload_byte = rx_byte;
                    res.byte_index   = count_reg;
                    sum_next         = sum_reg + rx_byte;
                    count_next       = count_reg + 7'd1;
                    phase_next       = PH_DATA;
                end
                else
                begin
                    // checksum byte closes the frame
                    res.end_of_frame = 1'b1;
                    res.checksum_ok  = (sum_reg == rx_byte);
                end
            end
            default:
            begin
                // hunting the first sync byte
                if (rx_byte == SYNC_BYTE0)
                begin
                    sum_next   = rx_byte;
                    phase_next = PH_SYNC1;
                end
            end
        endcase

        // buffer boundary restarts the hunt
        if (end_of_burst)
        begin
            phase_next = PH_SYNC0;
        end
    end

endmodule

[sv/slcd_out_stage.sv]
// result register driving the result channel
module slcd_out_stage
    import slcd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  result_t       din,
    output logic          can_load,
    slcd_result_if.source res
);

    logic    valid_reg;
    result_t data_reg;

    // slot is free when empty or being drained this cycle
    assign can_load = !valid_reg || res.ready;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            data_reg <= din;
        end
    end

    assign res.valid        = valid_reg;
    assign res.end_of_frame = data_reg.end_of_frame;
    assign res.payload_byte = data_reg.payload_byte;
    assign res.byte_index   = data_reg.byte_index;
    assign res.command      = data_reg.command;
    assign res.frame_length = data_reg.frame_length;
    assign res.checksum_ok  = data_reg.checksum_ok;

endmodule

[sv/sync_length_checksum_deframer_core.sv]
// top level of the sync/length/checksum deframer
//
// rx carries one received byte per transfer with an end_of_burst mark.
// The block hunts for sync 55 AA 02, takes two header bytes, a command
// byte (at most max_command) and a big-endian 16-bit length (at most
// max_payload and below 128), streams each payload byte out on res as a
// transfer with its index, then closes the frame with an end_of_frame
// transfer that carries checksum_ok for the 8-bit additive sum.
// Bytes outside a frame give no transfer on res.
// A byte waits in the input register, passes the single parser step and,
// if it gives a result, moves into the result register; the result is
// valid on res as soon as it is loaded. Throughput: one byte per cycle
// while res does not stall.
// When res stalls, the result register holds, the input register fills,
// and rx.ready drops only once both are occupied.
// Reset clears the pipeline, returns the parser to hunting and loads
// max_command = 36 and max_payload = 127. The cfg port writes a register
// at any edge with cfg_we high; write only while the block is idle.
module sync_length_checksum_deframer_core
    import slcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    slcd_byte_if.sink             rx,
    slcd_result_if.source         res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eob_reg;
    logic [7:0] max_command_reg;
    logic [6:0] max_payload_reg;

    logic    step;
    logic    can_load;
    logic    parse_valid;
    result_t parse_res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_command_reg <= MAX_COMMAND_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_COMMAND: max_command_reg <= cfg_data;
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data[6:0];
                default:         max_command_reg <= max_command_reg;
            endcase
        end
    end

    // input register advances into the parser when the result slot is free
    assign step     = in_valid_reg && can_load;
    assign rx.ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
            in_eob_reg  <= rx.end_of_burst;
        end
    end

    // parser
    slcd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .rx_byte      (in_byte_reg),
        .end_of_burst (in_eob_reg),
        .max_command  (max_command_reg),
        .max_payload  (max_payload_reg),
        .res_valid    (parse_valid),
        .res          (parse_res)
    );

    // result register
    slcd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step && parse_valid),
        .din      (parse_res),
        .can_load (can_load),
        .res      (res)
    );

endmodule

[tb/tb_sync_length_checksum_deframer_core.sv]
// testbench for the sync/length/checksum deframer core: framed and noisy byte streams vs a parser model
`timescale 1ns / 100ps

module tb_sync_length_checksum_deframer_core;
    import slcd_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_PRINTED      = 40;

    typedef struct packed {
        logic [7:0] value;
        logic       eob;
    } rx_item_t;

    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PERIODIC
    } ready_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    slcd_byte_if   rx();
    slcd_result_if res();

    sync_length_checksum_deframer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // bytes waiting to be sent and result transfers still to come
    rx_item_t rx_items[$];
    result_t  expected_results[$];

    // parser model state and its copy of the limits
    phase_t     parse_phase  = PH_SYNC0;
    logic [7:0] frame_total  = '0;
    logic [7:0] frame_cmd    = '0;
    logic [7:0] len_hi       = '0;
    logic [6:0] data_len     = '0;
    logic [6:0] data_count   = '0;
    logic [7:0] lim_command  = MAX_COMMAND_RESET;
    logic [6:0] lim_payload  = MAX_PAYLOAD_RESET;

    // run statistics
    int mismatches   = 0;
    int bytes_sent   = 0;
    int payload_seen = 0;
    int good_frames  = 0;
    int bad_frames   = 0;
    int cmd_rejects  = 0;
    int len_rejects  = 0;
    int limit_sets   = 1;
    int cycles       = 0;

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall shaping
    int          long_stall_req  = 0;
    int          long_stall_seen = 0;
    int          hold_left       = 0;
    int          rcv_tick        = 0;
    int          ready_mode_left = 0;
    ready_mode_t ready_mode      = RDY_ALWAYS;

    result_t got_r;
    result_t want_r;

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // one received byte through the parser model
    task automatic parse_rx_byte(input logic [7:0] b, input logic eob);
        logic [15:0] len;
        result_t     r;
        r = '0;
        case (parse_phase)
            PH_SYNC1:
            begin
                if (b == SYNC_BYTE1)
                begin
                    frame_total = frame_total + b;
                    parse_phase = PH_SYNC2;
                end
                else
                    parse_phase = PH_SYNC0;
            end
            PH_SYNC2:
            begin
                if (b == SYNC_BYTE2)
                begin
                    frame_total = frame_total + b;
                    parse_phase = PH_HDR0;
                end
                else
                    parse_phase = PH_SYNC0;
            end
            PH_HDR0:
            begin
                frame_total = frame_total + b;
                parse_phase = PH_HDR1;
            end
            PH_HDR1:
            begin
                frame_total = frame_total + b;
                parse_phase = PH_CMD;
            end
            PH_CMD:
            begin
                if (b <= lim_command)
                begin
                    frame_cmd   = b;
                    frame_total = frame_total + b;
                    parse_phase = PH_LENH;
                end
                else
                begin
                    cmd_rejects++;
                    parse_phase = PH_SYNC0;
                end
            end
            PH_LENH:
            begin
                len_hi      = b;
                parse_phase = PH_LENL;
            end
            PH_LENL:
            begin
                len = {len_hi, b};
                if (len <= {9'd0, lim_payload} && len < 16'(MAX_PAYLOAD_BYTES))
                begin
                    data_len    = len[6:0];
                    data_count  = '0;
                    frame_total = frame_total + len_hi + b;
                    parse_phase = PH_DATA;
                end
                else
                begin
                    len_rejects++;
                    parse_phase = PH_SYNC0;
                end
            end
            PH_DATA:
            begin
                r.command      = frame_cmd;
                r.frame_length = data_len;
                if (data_count < data_len)
                begin
                    r.payload_byte = b;
                    r.byte_index   = data_count;
                    frame_total    = frame_total + b;
                    data_count     = data_count + 7'd1;
                    payload_seen++;
                end
                else
                begin
                    r.end_of_frame = 1'b1;
                    r.checksum_ok  = (frame_total == b);
                    if (r.checksum_ok)
                        good_frames++;
                    else
                        bad_frames++;
                    parse_phase = PH_SYNC0;
                end
                expected_results.push_back(r);
            end
            default:
            begin
                if (b == SYNC_BYTE0)
                begin
                    frame_total = b;
                    parse_phase = PH_SYNC1;
                end
                else
                    parse_phase = PH_SYNC0;
            end
        endcase
        // end of burst always sends the parser back to hunting
        if (eob)
            parse_phase = PH_SYNC0;
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns: %s got %0h, expected %0h", $time, what, got_v, want_v);
    endtask

    task automatic push_byte(input logic [7:0] value, input logic eob);
        rx_items.push_back('{value: value, eob: eob});
    endtask

    // one frame with its additive checksum, good or spoiled
    task automatic queue_frame(input logic [7:0] hdr0, input logic [7:0] hdr1,
                               input logic [7:0] cmd, input logic [15:0] len,
                               input int n_data, input bit good_sum, input int eob_at);
        logic [7:0] fb[$];
        logic [7:0] total;
        fb = '{SYNC_BYTE0, SYNC_BYTE1, SYNC_BYTE2, hdr0, hdr1, cmd, len[15:8], len[7:0]};
        repeat (n_data) fb.push_back(8'($urandom));
        total = '0;
        foreach (fb[i]) total = total + fb[i];
        fb.push_back(good_sum ? total : total + 8'($urandom_range(1, 255)));
        foreach (fb[i]) push_byte(fb[i], i == eob_at);
    endtask

    // mostly well-formed frames, the rest rejected headers and line noise
    task automatic queue_random_traffic(input int n_bytes);
        int          goal;
        int          pick;
        int          len_cap;
        int          frame_len;
        int          eob_at;
        logic [7:0]  cmd;
        logic [15:0] len;
        goal    = rx_items.size() + n_bytes;
        len_cap = (lim_payload < 12) ? int'(lim_payload) : 12;
        while (rx_items.size() < goal)
        begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0:       cmd = lim_command;
                1:       cmd = 8'h00;
                default: cmd = 8'($urandom_range(0, int'(lim_command)));
            endcase
            if (pick < 68)
            begin
                if ($urandom_range(0, 39) == 0)
                    frame_len = lim_payload;
                else
                    frame_len = $urandom_range(0, len_cap);
                case ($urandom_range(0, 9))
                    0, 1, 2: eob_at = 8 + frame_len;
                    3:       eob_at = $urandom_range(0, 8 + frame_len);
                    default: eob_at = -1;
                endcase
                queue_frame(8'($urandom), 8'($urandom), cmd, 16'(frame_len), frame_len,
                            $urandom_range(0, 3) != 0, eob_at);
            end
            else if (pick < 78 && lim_command != 8'hFF)
            begin
                cmd = 8'($urandom_range(int'(lim_command) + 1, 255));
                queue_frame(8'($urandom), 8'($urandom), cmd, 16'(len_cap), len_cap, 1'b1, -1);
            end
            else if (pick < 88)
            begin
                if ($urandom_range(0, 1) == 1)
                    len = {8'($urandom_range(1, 255)), 8'($urandom)};
                else
                    len = 16'($urandom_range(int'(lim_payload) + 1, 255));
                queue_frame(8'($urandom), 8'($urandom), cmd, len, $urandom_range(0, 4),
                            1'b1, -1);
            end
            else
            begin
                case ($urandom_range(0, 2))
                    // doubled first sync byte does not start a frame
                    0:
                    begin
                        push_byte(SYNC_BYTE0, 1'b0);
                        push_byte(SYNC_BYTE0, 1'b0);
                        push_byte(SYNC_BYTE1, 1'b0);
                        push_byte(SYNC_BYTE2, 1'b0);
                        repeat ($urandom_range(1, 6)) push_byte(8'($urandom), 1'b0);
                    end
                    // sync broken at the third byte
                    1:
                    begin
                        push_byte(SYNC_BYTE0, 1'b0);
                        push_byte(SYNC_BYTE1, 1'b0);
                        push_byte(8'($urandom), $urandom_range(0, 3) == 0);
                    end
                    default:
                        repeat ($urandom_range(1, 8))
                            push_byte(8'($urandom), $urandom_range(0, 3) == 0);
                endcase
            end
        end
    endtask

    // wait for all bytes to go in and all results to come out, then let the pipe empty
    task automatic drain_and_settle();
        while (rx_items.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limits(input logic [7:0] cmd_lim, input logic [6:0] len_lim);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_COMMAND;
        cfg_data  <= cmd_lim;
        @(posedge clk);
        cfg_index <= REG_MAX_PAYLOAD;
        cfg_data  <= {1'b0, len_lim};
        @(posedge clk);
        cfg_we      <= 1'b0;
        lim_command = cmd_lim;
        lim_payload = len_lim;
        limit_sets++;
    endtask

    // byte sender: bursts with gaps, a byte stays on the bus until its transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx.valid && rx.ready)
            begin
                parse_rx_byte(rx.rx_byte, rx.end_of_burst);
                void'(rx_items.pop_front());
                bytes_sent++;
            end
            if (!rx.valid || rx.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    rx.valid <= 1'b0;
                end
                else if (rx_items.size() > 0)
                begin
                    rx.valid        <= 1'b1;
                    rx.rx_byte      <= rx_items[0].value;
                    rx.end_of_burst <= rx_items[0].eob;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    rx.valid <= 1'b0;
            end
        end
    end

    // result receiver: ready pattern changes at random intervals, plus a long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rcv_tick++;
            if (long_stall_req != long_stall_seen)
            begin
                long_stall_seen = long_stall_req;
                hold_left       = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                if (ready_mode_left == 0)
                begin
                    ready_mode      = ready_mode_t'($urandom_range(0, 3));
                    ready_mode_left = $urandom_range(16, 96);
                end
                ready_mode_left--;
                case (ready_mode)
                    RDY_ALWAYS: res.ready <= 1'b1;
                    RDY_COIN:   res.ready <= ($urandom_range(0, 1) == 1);
                    RDY_SPARSE: res.ready <= ($urandom_range(0, 3) == 0);
                    default:    res.ready <= (rcv_tick % 5 != 0);
                endcase
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            got_r = '{end_of_frame: res.end_of_frame, payload_byte: res.payload_byte,
                      byte_index: res.byte_index, command: res.command,
                      frame_length: res.frame_length, checksum_ok: res.checksum_ok};
            if (expected_results.size() == 0)
                flag_mismatch("result transfer with nothing expected", got_r, 0);
            else
            begin
                want_r = expected_results.pop_front();
                if (got_r.end_of_frame !== want_r.end_of_frame)
                    flag_mismatch("end_of_frame", got_r.end_of_frame, want_r.end_of_frame);
                if (got_r.payload_byte !== want_r.payload_byte)
                    flag_mismatch("payload_byte", got_r.payload_byte, want_r.payload_byte);
                if (got_r.byte_index !== want_r.byte_index)
                    flag_mismatch("byte_index", got_r.byte_index, want_r.byte_index);
                if (got_r.command !== want_r.command)
                    flag_mismatch("command", got_r.command, want_r.command);
                if (got_r.frame_length !== want_r.frame_length)
                    flag_mismatch("frame_length", got_r.frame_length, want_r.frame_length);
                if (got_r.checksum_ok !== want_r.checksum_ok)
                    flag_mismatch("checksum_ok", got_r.checksum_ok, want_r.checksum_ok);
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("tb_sync_length_checksum_deframer_core: errors");
            $finish;
        end
    end

    // reset, then one stream per limit setting
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_MAX_COMMAND;
        cfg_data        = '0;
        rx.valid        = 1'b0;
        rx.rx_byte      = '0;
        rx.end_of_burst = 1'b0;
        res.ready       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset limits: empty frame, frame at the command limit with a bad sum,
        // command one above the limit, end of burst right after a first sync byte
        @(negedge clk);
        queue_frame(8'hFF, 8'hFF, 8'h00, 16'd0, 0, 1'b1, -1);
        queue_frame(8'h00, 8'h00, MAX_COMMAND_RESET, 16'd1, 1, 1'b0, 9);
        push_byte(SYNC_BYTE0, 1'b0);
        push_byte(SYNC_BYTE1, 1'b0);
        push_byte(SYNC_BYTE2, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(MAX_COMMAND_RESET + 8'd1, 1'b0);
        push_byte(SYNC_BYTE0, 1'b1);
        push_byte(SYNC_BYTE1, 1'b0);
        push_byte(SYNC_BYTE2, 1'b0);
        queue_random_traffic(250);
        drain_and_settle();

        // widest limits, one frame of the largest payload
        set_limits(8'hFF, 7'd127);
        @(negedge clk);
        queue_frame(8'($urandom), 8'($urandom), 8'hFF, 16'd127, 127, 1'b1, 135);
        queue_random_traffic(220);
        drain_and_settle();

        // narrowest limits: only command 0 with empty payload gets through
        set_limits(8'h00, 7'd0);
        @(negedge clk);
        queue_random_traffic(150);
        drain_and_settle();

        // arbitrary limits
        set_limits(8'($urandom_range(1, 254)), 7'($urandom_range(1, 126)));
        @(negedge clk);
        queue_random_traffic(200);
        drain_and_settle();

        // long receiver hold-off while a long frame streams in
        set_limits(MAX_COMMAND_RESET, 7'd40);
        @(negedge clk);
        queue_frame(8'($urandom), 8'($urandom), 8'd5, 16'd24, 24, 1'b1, -1);
        long_stall_req++;
        queue_random_traffic(230);
        drain_and_settle();
        repeat (8) @(posedge clk);

        if (expected_results.size() != 0)
            flag_mismatch("results never delivered", expected_results.size(), 0);
        $display("covered %0d received bytes over %0d limit settings, %0d payload bytes out",
                 bytes_sent, limit_sets, payload_seen);
        $display("frames closed %0d good / %0d bad checksum, headers dropped %0d cmd / %0d len",
                 good_frames, bad_frames, cmd_rejects, len_rejects);
        if (mismatches == 0)
            $display("tb_sync_length_checksum_deframer_core: clean");
        else
            $display("tb_sync_length_checksum_deframer_core: errors");
        $finish;
    end

endmodule

[sim.f]
sv/slcd_pkg.sv
sv/slcd_byte_if.sv
sv/slcd_parser.sv
sv/slcd_out_stage.sv
sv/sync_length_checksum_deframer_core.sv
tb/tb_sync_length_checksum_deframer_core.sv
